>>> rtl/core/owcq_pkg.sv
// Shared types, codes and helpers for the occupancy window cost query.
// Used by owcq_scan, the top level and the bench; depends on nothing else.
package owcq_pkg;

   localparam int GRID_DIM_DEF = 256;
   localparam int MASK_MAX_DEF = 32;

   localparam int COST_W = 16;
   localparam int COORD_W = 16;
   localparam int OFF_W = 7;    // window offsets, -63..63
   localparam int LOC_W = 18;   // local cell coordinate, signed
   localparam int DIM_W = 11;   // grid size after clamping, at most GRID_DIM
   localparam int OCC_W = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [COST_W-1:0] COST_ONE = 16'd256;

   typedef enum logic [1:0] {
      MODE_OCC_WRITE  = 2'd0,
      MODE_MASK_WRITE = 2'd1,
      MODE_QUERY      = 2'd2,
      MODE_NONE       = 2'd3
   } mode_type;

   typedef enum logic [OCC_W-1:0] {
      OCC_FREE     = 2'd0,
      OCC_OCCUPIED = 2'd1,
      OCC_UNKNOWN  = 2'd2,
      OCC_BAD      = 2'd3
   } occ_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNKNOWN_OBST = 3'd0,
      CSR_CEILING      = 3'd1,
      CSR_MASK_EXTENT  = 3'd2,
      CSR_ORIGIN_X     = 3'd3,
      CSR_ORIGIN_Y     = 3'd4,
      CSR_GRID_WIDTH   = 3'd5,
      CSR_GRID_HEIGHT  = 3'd6,
      CSR_SPARE        = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_DRAIN,
      SCAN_DONE
   } scan_state_type;

   // Configuration as seen by the scan unit, extents already clamped
   typedef struct packed {
      logic               unknown_obst;
      logic [COST_W-1:0]  ceiling;
      logic [OFF_W-1:0]   extent;
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } scan_status_type;

   // Local coordinate: coord + offset - origin, sign-extended
   function automatic logic [LOC_W-1:0] local_coord(input logic [COORD_W-1:0] c,
                                                    input logic [COORD_W-1:0] o,
                                                    input logic [OFF_W-1:0] d);
      logic [LOC_W-1:0] ce;
      logic [LOC_W-1:0] oe;
      logic [LOC_W-1:0] de;
      ce = {{(LOC_W-COORD_W){c[COORD_W-1]}}, c};
      oe = {{(LOC_W-COORD_W){o[COORD_W-1]}}, o};
      de = {{(LOC_W-OFF_W){d[OFF_W-1]}}, d};
      return ce + de - oe;
   endfunction

   // True when 0 <= v < lim
   function automatic logic in_span(input logic [LOC_W-1:0] v,
                                    input logic [DIM_W-1:0] lim);
      return !v[LOC_W-1] && (v < {{(LOC_W-DIM_W){1'b0}}, lim});
   endfunction

   function automatic logic [OFF_W-2:0] abs_off(input logic [OFF_W-1:0] d);
      logic [OFF_W-1:0] n;
      n = d[OFF_W-1] ? (~d + 1'b1) : d;
      return n[OFF_W-2:0];
   endfunction

endpackage

>>> rtl/core/owcq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Stand-alone; no package needed.
module owcq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read first port, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/owcq_scan.sv
// Query sequencer: walks the window one cell a cycle, reads both RAMs and
// keeps the running maximum. Depends on owcq_pkg.
module owcq_scan #(
   parameter int GRID_DIM = owcq_pkg::GRID_DIM_DEF,
   parameter int MASK_MAX = owcq_pkg::MASK_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [owcq_pkg::COORD_W-1:0]          start_x,
   input  logic [owcq_pkg::COORD_W-1:0]          start_y,
   input  owcq_pkg::cfg_type                     cfg,
   input  logic                                  out_free,
   output owcq_pkg::scan_status_type             status,
   output logic [$clog2(GRID_DIM*GRID_DIM)-1:0]  occ_addr,
   output logic [$clog2(MASK_MAX*MASK_MAX)-1:0]  mask_addr,
   input  logic [owcq_pkg::OCC_W-1:0]            occ_rdata,
   input  logic [owcq_pkg::COST_W-1:0]           mask_rdata,
   output logic [owcq_pkg::COST_W-1:0]           cost
);
   import owcq_pkg::*;

   localparam int OAW = $clog2(GRID_DIM*GRID_DIM);
   localparam int MAW = $clog2(MASK_MAX*MASK_MAX);

   scan_state_type state_ff, state_in;
   logic [COORD_W-1:0] qx_ff, qx_in;
   logic [COORD_W-1:0] qy_ff, qy_in;
   logic [OFF_W-1:0]   dx_ff, dx_in;
   logic [OFF_W-1:0]   dy_ff, dy_in;
   logic [COST_W-1:0]  best_ff, best_in;
   logic               pend_ff, pend_in;

   logic [OFF_W-1:0] first_off;
   logic [OFF_W-1:0] last_off;
   logic [LOC_W-1:0] lx;
   logic [LOC_W-1:0] ly;
   logic             on_grid;
   logic             row_end;
   logic             hit;

   assign first_off = 7'd1 - cfg.extent;
   assign last_off = cfg.extent - 7'd1;
   assign row_end = (dx_ff == last_off);

   // Address of the current window cell
   assign lx = local_coord(qx_ff, cfg.origin_x, dx_ff);
   assign ly = local_coord(qy_ff, cfg.origin_y, dy_ff);
   assign on_grid = in_span(lx, cfg.width) && in_span(ly, cfg.height);
   assign occ_addr = OAW'(ly * GRID_DIM + lx);
   assign mask_addr = MAW'(abs_off(dy_ff) * MASK_MAX + abs_off(dx_ff));

   assign hit = (occ_rdata == OCC_OCCUPIED) ||
                (cfg.unknown_obst && (occ_rdata == OCC_UNKNOWN));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCAN_IDLE: begin
            if (start) begin
               state_in = (cfg.extent == '0) ? SCAN_DONE : SCAN_RUN;
            end
         end
         SCAN_RUN: begin
            if (row_end && (dy_ff == last_off)) begin
               state_in = SCAN_DRAIN;
            end
         end
         SCAN_DRAIN: state_in = SCAN_DONE;
         SCAN_DONE: begin
            if (out_free) begin
               state_in = SCAN_IDLE;
            end
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   // Counters, pending read and running maximum
   always_comb begin
      qx_in = qx_ff;
      qy_in = qy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      best_in = best_ff;
      pend_in = 1'b0;
      if (pend_ff && hit && (mask_rdata > best_ff)) begin
         best_in = mask_rdata;
      end
      unique case (state_ff)
         SCAN_IDLE: begin
            if (start) begin
               qx_in = start_x;
               qy_in = start_y;
               dx_in = first_off;
               dy_in = first_off;
               best_in = COST_ONE;
            end
         end
         SCAN_RUN: begin
            pend_in = on_grid;
            if (row_end) begin
               dx_in = first_off;
               dy_in = dy_ff + 7'd1;
            end else begin
               dx_in = dx_ff + 7'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
      end
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      best_ff <= best_in;
   end

   // Outputs
   always_comb begin
      status.idle = (state_ff == SCAN_IDLE);
      status.done = (state_ff == SCAN_DONE) && out_free;
      cost = (best_ff > cfg.ceiling) ? cfg.ceiling : best_ff;
   end

endmodule

>>> rtl/core/occupancy_window_cost_query_top.sv
// Top level of the occupancy window cost query: ports, configuration,
// store writes and result register. Depends on owcq_pkg, owcq_ram, owcq_scan.
//
// Use: req_ carries one item per transfer; req_tuser is the mode (occupancy
// write, mask write, query). Writes give no result.
// A query walks its (2E-1) x (2E-1) window one cell a cycle, where
// E = min(mask_extent, MASK_MAX), reading the occupancy and mask RAMs
// together; the result then passes through the drain and done states
// into the result register. An extent of zero skips the walk.
// One query is in flight at a time; req_tready is high while the sequencer
// is idle, so writes may follow each other every cycle.
// The cost sits in an output register; if the receiver stalls, a finished
// query holds in the sequencer until the register frees, while the
// register itself keeps rsp_tvalid and rsp_tdata steady.
// Reset restores the configuration defaults and empties the result
// register. The stores are not cleared and must be loaded before queries.
// csr_ writes take effect at once and must be made while the block idles.
module occupancy_window_cost_query_top #(
   parameter int GRID_DIM = owcq_pkg::GRID_DIM_DEF,
   parameter int MASK_MAX = owcq_pkg::MASK_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coord_x [15:0], coord_y [31:16], write_value [47:32]
   input  logic [47:0]                       req_tdata,
   // mode [1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cost [15:0]
   output logic [owcq_pkg::COST_W-1:0]       rsp_tdata,
   input  logic                              csr_we,
   input  logic [owcq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_wdata
);
   import owcq_pkg::*;

   localparam int OAW = $clog2(GRID_DIM*GRID_DIM);
   localparam int MAW = $clog2(MASK_MAX*MASK_MAX);

   logic               uio_ff;
   logic [COST_W-1:0]  ceil_ff;
   logic [5:0]         ext_ff;
   logic [COORD_W-1:0] ox_ff;
   logic [COORD_W-1:0] oy_ff;
   logic [8:0]         gw_ff;
   logic [8:0]         gh_ff;
   logic               rsp_valid_ff;
   logic [COST_W-1:0]  rsp_data_ff;

   cfg_type            cfg;
   scan_status_type    status;
   mode_type           mode;
   logic [COORD_W-1:0] in_x;
   logic [COORD_W-1:0] in_y;
   logic [COST_W-1:0]  in_val;
   logic               accept;
   logic               occ_we;
   logic               mask_we;
   logic               out_free;
   logic [LOC_W-1:0]   wlx;
   logic [LOC_W-1:0]   wly;
   logic [OAW-1:0]     scan_occ_addr;
   logic [MAW-1:0]     scan_mask_addr;
   logic [OAW-1:0]     occ_addr;
   logic [MAW-1:0]     mask_addr;
   logic [OCC_W-1:0]   occ_rdata;
   logic [COST_W-1:0]  mask_rdata;
   logic [COST_W-1:0]  cost;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         uio_ff <= 1'b0;
         ceil_ff <= 16'hFFFF;
         ext_ff <= 6'd32;
         ox_ff <= '0;
         oy_ff <= '0;
         gw_ff <= 9'd256;
         gh_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_UNKNOWN_OBST: uio_ff <= csr_wdata[0];
            CSR_CEILING:      ceil_ff <= csr_wdata;
            CSR_MASK_EXTENT:  ext_ff <= csr_wdata[5:0];
            CSR_ORIGIN_X:     ox_ff <= csr_wdata;
            CSR_ORIGIN_Y:     oy_ff <= csr_wdata;
            CSR_GRID_WIDTH:   gw_ff <= csr_wdata[8:0];
            CSR_GRID_HEIGHT:  gh_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Clamp extents to the built sizes
   always_comb begin
      cfg.unknown_obst = uio_ff;
      cfg.ceiling = ceil_ff;
      cfg.extent = ({1'b0, ext_ff} > OFF_W'(MASK_MAX)) ? OFF_W'(MASK_MAX) : {1'b0, ext_ff};
      cfg.origin_x = ox_ff;
      cfg.origin_y = oy_ff;
      cfg.width = ({2'b0, gw_ff} > DIM_W'(GRID_DIM)) ? DIM_W'(GRID_DIM) : {2'b0, gw_ff};
      cfg.height = ({2'b0, gh_ff} > DIM_W'(GRID_DIM)) ? DIM_W'(GRID_DIM) : {2'b0, gh_ff};
   end

   // Unpack the request
   assign mode = mode_type'(req_tuser);
   assign in_x = req_tdata[15:0];
   assign in_y = req_tdata[31:16];
   assign in_val = req_tdata[47:32];
   assign req_tready = status.idle;
   assign accept = req_tvalid && req_tready;

   // Store writes, dropped when off the grid or out of range
   assign wlx = local_coord(in_x, ox_ff, '0);
   assign wly = local_coord(in_y, oy_ff, '0);
   assign occ_we = accept && (mode == MODE_OCC_WRITE) && (in_val <= 16'd2) &&
                   in_span(wlx, cfg.width) && in_span(wly, cfg.height);
   assign mask_we = accept && (mode == MODE_MASK_WRITE) &&
                    !in_x[COORD_W-1] && (in_x < COORD_W'(MASK_MAX)) &&
                    !in_y[COORD_W-1] && (in_y < COORD_W'(MASK_MAX));

   assign occ_addr = occ_we ? OAW'(wly * GRID_DIM + wlx) : scan_occ_addr;
   assign mask_addr = mask_we ? MAW'(in_y * MASK_MAX + in_x) : scan_mask_addr;

   owcq_ram #(
      .WIDTH(OCC_W),
      .DEPTH(GRID_DIM*GRID_DIM)
   ) u_occ_ram (
      .clock(clock),
      .we(occ_we),
      .addr(occ_addr),
      .wdata(in_val[OCC_W-1:0]),
      .rdata(occ_rdata)
   );

   owcq_ram #(
      .WIDTH(COST_W),
      .DEPTH(MASK_MAX*MASK_MAX)
   ) u_mask_ram (
      .clock(clock),
      .we(mask_we),
      .addr(mask_addr),
      .wdata(in_val),
      .rdata(mask_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   owcq_scan #(
      .GRID_DIM(GRID_DIM),
      .MASK_MAX(MASK_MAX)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .start(accept && (mode == MODE_QUERY)),
      .start_x(in_x),
      .start_y(in_y),
      .cfg(cfg),
      .out_free(out_free),
      .status(status),
      .occ_addr(scan_occ_addr),
      .mask_addr(scan_mask_addr),
      .occ_rdata(occ_rdata),
      .mask_rdata(mask_rdata),
      .cost(cost)
   );

   // Result register: load on completion, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (status.done) begin
         rsp_data_ff <= cost;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for occupancy_window_cost_query_top: a directed table
// with fixed expected costs, then randomised phases checked against an
// in-bench cost predictor. Depends on owcq_pkg and the RTL of the block only.
module tb_top;
   import owcq_pkg::*;

   localparam int GDIM = 256;
   localparam int MMAX = 32;
   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct {
      bit            is_csr;
      csr_index_type idx;
      mode_type      mode;
      int            x;
      int            y;
      int            v;
      bit            fixed;
      logic [15:0]   cost;
   } stim_row_t;

   typedef struct {
      bit uio;
      int ceil;
      int ext;
      int ox;
      int oy;
      int w;
      int h;
      int n;
   } phase_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predictor state
   logic [1:0]  occ_grid [GDIM*GDIM];
   bit          occ_seen [GDIM*GDIM];
   logic [15:0] mask_cost [MMAX*MMAX];
   bit          mask_seen [MMAX*MMAX];
   bit          p_uio;
   logic [15:0] p_ceil;
   logic [5:0]  p_ext;
   int          p_ox, p_oy;
   logic [8:0]  p_w, p_h;

   logic [15:0] cost_due[$];
   stim_row_t   dir_rows[$];
   int          errors = 0;
   int          cycles = 0;
   int          sent = 0;
   int          send_idle = 33;
   int          recv_idle = 85;

   occupancy_window_cost_query_top u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   always #6 clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stall the result channel
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // compare each result transfer with the oldest expected cost
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cost_due.size() == 0) begin
            $error("cost: no result expected, actual %h", rsp_tdata);
            errors++;
         end else begin
            if (rsp_tdata !== cost_due[0]) begin
               $error("cost mismatch: expected %h, actual %h", cost_due[0], rsp_tdata);
               errors++;
            end
            void'(cost_due.pop_front());
         end
      end
   end

   function automatic int clip16(int v);
      return (v < -32768) ? -32768 : (v > 32767) ? 32767 : v;
   endfunction

   function automatic int eff_ext();
      return (p_ext > MMAX) ? MMAX : int'(p_ext);
   endfunction

   function automatic int eff_w();
      return (p_w > GDIM) ? GDIM : int'(p_w);
   endfunction

   function automatic int eff_h();
      return (p_h > GDIM) ? GDIM : int'(p_h);
   endfunction

   // max of the mask over obstacles in the clipped window, floor 1.0, clamp
   function automatic logic [15:0] window_cost(int qx, int qy);
      int          e, lx, ly, ax, ay;
      logic [15:0] best;
      logic [1:0]  o;
      e = eff_ext();
      best = COST_ONE;
      for (int dy = 1 - e; dy < e; dy++) begin
         ly = qy + dy - p_oy;
         if (ly < 0 || ly >= eff_h()) continue;
         for (int dx = 1 - e; dx < e; dx++) begin
            lx = qx + dx - p_ox;
            if (lx < 0 || lx >= eff_w()) continue;
            o = occ_grid[ly*GDIM + lx];
            if (o == OCC_OCCUPIED || (p_uio && o == OCC_UNKNOWN)) begin
               ax = (dx < 0) ? -dx : dx;
               ay = (dy < 0) ? -dy : dy;
               if (mask_cost[ay*MMAX + ax] > best) best = mask_cost[ay*MMAX + ax];
            end
         end
      end
      return (best > p_ceil) ? p_ceil : best;
   endfunction

   // drop the request and wait until every result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (cost_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, int val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         CSR_UNKNOWN_OBST: p_uio  = val[0];
         CSR_CEILING:      p_ceil = val[15:0];
         CSR_MASK_EXTENT:  p_ext  = val[5:0];
         CSR_ORIGIN_X:     p_ox   = int'($signed(val[15:0]));
         CSR_ORIGIN_Y:     p_oy   = int'($signed(val[15:0]));
         CSR_GRID_WIDTH:   p_w    = val[8:0];
         CSR_GRID_HEIGHT:  p_h    = val[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one request transfer; called and returns at a falling edge
   task automatic send_item(mode_type m, int x, int y, int v, bit fixed = 0,
                            logic [15:0] fcost = '0);
      int lx, ly;
      if (sent < 550) begin
         send_idle = 33; recv_idle = 85;
      end else if (sent < 1100) begin
         send_idle = 85; recv_idle = 33;
      end else begin
         send_idle = 0; recv_idle = 0;
      end
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {v[15:0], y[15:0], x[15:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      // advance the predictor on the accepted transfer
      x = int'($signed(x[15:0]));
      y = int'($signed(y[15:0]));
      case (m)
         MODE_OCC_WRITE: begin
            lx = x - p_ox;
            ly = y - p_oy;
            if (v[15:0] <= 2 && lx >= 0 && lx < eff_w() && ly >= 0 && ly < eff_h()) begin
               occ_grid[ly*GDIM + lx] = v[1:0];
               occ_seen[ly*GDIM + lx] = 1'b1;
            end
         end
         MODE_MASK_WRITE: begin
            if (x >= 0 && x < MMAX && y >= 0 && y < MMAX) begin
               mask_cost[y*MMAX + x] = v[15:0];
               mask_seen[y*MMAX + x] = 1'b1;
            end
         end
         MODE_QUERY: cost_due.push_back(fixed ? fcost : window_cost(x, y));
         default: ;
      endcase
      @(negedge clock);
   endtask

   // load every store entry the query at (qx, qy) will read
   task automatic prime_window(int qx, int qy);
      int e, lx, ly, ax, ay;
      e = eff_ext();
      for (int dy = 1 - e; dy < e; dy++) begin
         ly = qy + dy - p_oy;
         if (ly < 0 || ly >= eff_h()) continue;
         ay = (dy < 0) ? -dy : dy;
         for (int dx = 1 - e; dx < e; dx++) begin
            lx = qx + dx - p_ox;
            if (lx < 0 || lx >= eff_w()) continue;
            ax = (dx < 0) ? -dx : dx;
            if (!mask_seen[ay*MMAX + ax])
               send_item(MODE_MASK_WRITE, ax, ay, $urandom_range(0, 65535));
            if (!occ_seen[ly*GDIM + lx])
               send_item(MODE_OCC_WRITE, p_ox + lx, p_oy + ly, $urandom_range(0, 2));
         end
      end
   endtask

   function automatic void r_csr(csr_index_type idx, int val);
      stim_row_t r;
      r = '{1'b1, idx, MODE_NONE, 0, 0, val, 1'b0, '0};
      dir_rows.push_back(r);
   endfunction

   function automatic void r_item(mode_type m, int x, int y, int v, bit fixed = 0,
                                  logic [15:0] c = '0);
      stim_row_t r;
      r = '{1'b0, CSR_SPARE, m, x, y, v, fixed, c};
      dir_rows.push_back(r);
   endfunction

   initial begin
      phase_t   phases[$];
      int       ext, w, h, qx, qy, pick;
      mode_type rm;
      int       rx, ry;

      for (int i = 0; i < GDIM*GDIM; i++) begin
         occ_grid[i] = '0; occ_seen[i] = 1'b0;
      end
      for (int i = 0; i < MMAX*MMAX; i++) begin
         mask_cost[i] = '0; mask_seen[i] = 1'b0;
      end
      p_uio = 1'b0; p_ceil = 16'hFFFF; p_ext = 6'd32;
      p_ox = 0; p_oy = 0; p_w = 9'd256; p_h = 9'd256;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a 4x4 grid at the coordinate extremes, single-cell window
      r_csr(CSR_MASK_EXTENT, 1);
      r_csr(CSR_GRID_WIDTH, 4);
      r_csr(CSR_GRID_HEIGHT, 4);
      r_csr(CSR_ORIGIN_X, -32768);
      r_csr(CSR_ORIGIN_Y, 32764);
      r_item(MODE_MASK_WRITE, 0, 0, 16'h0500);
      r_item(MODE_MASK_WRITE, 31, 31, 16'hFFFF);
      r_item(MODE_MASK_WRITE, 32, 0, 16'h1234);       // out of range, dropped
      r_item(MODE_MASK_WRITE, -1, 0, 16'h1234);       // negative dx, dropped
      r_item(MODE_OCC_WRITE, -32768, 32764, OCC_OCCUPIED);
      r_item(MODE_OCC_WRITE, -32767, 32764, OCC_UNKNOWN);
      r_item(MODE_OCC_WRITE, -32768, 32765, OCC_FREE);
      r_item(MODE_OCC_WRITE, -32768, 32764, OCC_BAD);  // bad value, dropped
      r_item(MODE_OCC_WRITE, -32764, 32764, OCC_FREE); // off the grid
      r_item(MODE_OCC_WRITE, 32767, 32767, 16'hFFFF);
      r_item(MODE_QUERY, -32768, 32764, 0, 1, 16'h0500);
      r_item(MODE_QUERY, -32767, 32764, 0, 1, COST_ONE);
      r_item(MODE_QUERY, -32768, 32765, 0, 1, COST_ONE);
      r_item(MODE_QUERY, 32767, -32768, 16'hFFFF, 1, COST_ONE);
      r_item(MODE_NONE, 16'h7FFF, -1, 16'hFFFF);
      r_csr(CSR_CEILING, 16'h0080);
      r_item(MODE_QUERY, -32768, 32764, 0, 1, 16'h0080);
      r_csr(CSR_CEILING, 0);
      r_csr(CSR_UNKNOWN_OBST, 1);
      r_item(MODE_QUERY, -32767, 32764, 0, 1, 16'h0000);
      r_csr(CSR_CEILING, 16'hFFFF);
      r_item(MODE_QUERY, -32767, 32764, 0, 1, 16'h0500);
      r_csr(CSR_MASK_EXTENT, 0);
      r_item(MODE_QUERY, -32768, 32764, 0, 1, COST_ONE);
      r_csr(CSR_MASK_EXTENT, 1);
      r_csr(CSR_GRID_WIDTH, 0);
      r_item(MODE_QUERY, -32768, 32764, 0, 1, COST_ONE);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) csr_write(dir_rows[i].idx, dir_rows[i].v);
         else send_item(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].v,
                        dir_rows[i].fixed, dir_rows[i].cost);
      end

      // random phases: uio, ceiling, extent, origin, size, items
      phases.push_back('{0, 65535, 3, 100, -50, 16, 16, 120});
      phases.push_back('{1, 16'h0400, 4, -20, 7, 8, 10, 120});
      phases.push_back('{1, 65535, 63, 0, 0, 511, 4, 20});
      phases.push_back('{0, 16'h0300, 2, -32768, 32758, 9, 10, 120});
      phases.push_back('{1, 65535, 5, -5, -5, 12, 8, 120});
      phases.push_back('{0, 16'h00FF, 1, 0, 0, 256, 256, 120});

      foreach (phases[p]) begin
         csr_write(CSR_UNKNOWN_OBST, phases[p].uio);
         csr_write(CSR_CEILING, phases[p].ceil);
         csr_write(CSR_MASK_EXTENT, phases[p].ext);
         csr_write(CSR_ORIGIN_X, phases[p].ox);
         csr_write(CSR_ORIGIN_Y, phases[p].oy);
         csr_write(CSR_GRID_WIDTH, phases[p].w);
         csr_write(CSR_GRID_HEIGHT, phases[p].h);
         ext = eff_ext();
         w = eff_w();
         h = eff_h();
         for (int n = 0; n < phases[p].n; n++) begin
            pick = $urandom_range(0, 99);
            if (ext == MMAX) begin
               // full window: keep queries near the lowest corner
               qx = p_ox + $urandom_range(0, 10) - 5;
               qy = p_oy + $urandom_range(0, 10) - 5;
               pick = 99;
            end else begin
               qx = clip16(p_ox + $urandom_range(0, w + 2*ext) - ext);
               qy = clip16(p_oy + $urandom_range(0, h + 2*ext) - ext);
            end
            if (pick < 5) begin
               rm = mode_type'($urandom_range(0, 3));
               rx = $urandom_range(0, 65535) - 32768;
               ry = $urandom_range(0, 65535) - 32768;
               if (rm == MODE_QUERY) prime_window(rx, ry);
               send_item(rm, rx, ry, $urandom_range(0, 65535));
            end else if (pick < 25) begin
               send_item(MODE_OCC_WRITE, qx, qy, $urandom_range(0, 3));
            end else if (pick < 37) begin
               send_item(MODE_MASK_WRITE, $urandom_range(0, ext), $urandom_range(0, ext),
                         $urandom_range(0, 65535));
            end else if (pick < 40) begin
               send_item(MODE_NONE, qx, qy, $urandom_range(0, 65535));
            end else if (pick < 45) begin
               qx = clip16(qx + ($urandom_range(0, 1) ? 40000 : -40000));
               prime_window(qx, qy);
               send_item(MODE_QUERY, qx, qy, $urandom_range(0, 65535));
            end else begin
               prime_window(qx, qy);
               send_item(MODE_QUERY, qx, qy, $urandom_range(0, 65535));
            end
         end
      end

      drain();
      repeat (200) @(negedge clock);
      if (errors == 0 && cost_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/owcq_pkg.sv
rtl/core/owcq_ram.sv
rtl/core/owcq_scan.sv
rtl/core/occupancy_window_cost_query_top.sv
tb/tb_top.sv
